FILE: hdl/b64se_pkg.sv
`default_nettype none

package b64se_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned CharW   = 7;
  localparam int unsigned MaxChars = 4;

  localparam logic [CharW-1:0] PAD_CHAR = 7'd61;

  // classified work for one byte: up to four characters, index of the last one
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;
    logic                           fin;
  } entry_t;

  // standard alphabet lookup for one 6-bit group
  function automatic logic [CharW-1:0] sym(input logic [5:0] six);
    logic [CharW-1:0] s;
    s = {1'b0, six};
    if (six < 6'd26) begin
      return s + 7'd65;
    end else if (six < 6'd52) begin
      return s + 7'd71;
    end else if (six < 6'd62) begin
      return s - 7'd4;
    end else if (six == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/b64se_channels.sv
`default_nettype none

interface b64se_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64se_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: hdl/base64_stream_encoder_unit.sv
// channel  | dir | words                          | accepted when
// ---------+-----+--------------------------------+----------------------
// in_i     | in  | data_byte[7:0], final_byte     | in_i.valid & in_i.ready
// out_o    | out | out_char[6:0], end_of_text     | out_o.valid & out_o.ready
//
// one character leaves per cycle while the queue holds work and out_o is not stalled;
// a byte yields 1 or 2 characters if non-final, 2 to 4 if final, and the output
// rate is bounded by the single-character output register.
// the first character of a byte passes the word queue, then the output register.
// reset is asynchronous, active low, and returns to the start of a 3-byte group.
// a stalled output fills the word queue, after which in_i.ready drops.
`default_nettype none

module base64_stream_encoder_unit #(
  parameter int unsigned QueueDepth = b64se_pkg::QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  b64se_byte_if.sink   in_i,
  b64se_char_if.source out_o
);

  // front to queue
  logic              push;
  logic              full;
  b64se_pkg::entry_t entry;

  // queue to back
  b64se_pkg::entry_t head;
  logic              empty;
  logic              pop;

  // front: tracks the group phase and carry, turns each byte into its characters
  b64se_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (entry)
  );

  // short queue of classified bytes so each side stalls on its own
  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  // back: walks the characters of the head entry into the output register
  b64se_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_char_o    (out_o.out_char),
    .end_of_text_o (out_o.end_of_text)
  );

  // queue can never look full and empty at once
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue full and empty together");

  // a stalled output word must not consume queue work
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !pop)
    else $error("queue popped while output stalled");

  // with nothing queued and nothing shown, no word can appear next cycle
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !out_o.valid) |=> !out_o.valid)
    else $error("output word without queued work");

  // nothing is popped from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hdl/b64se_front.sv
`default_nettype none

module b64se_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            final_byte_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output b64se_pkg::entry_t    entry_o
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    entry_o          = '0;
    entry_o.fin      = final_byte_i;
    phase_d          = PH_FIRST;
    carry_d          = '0;
    unique case (phase_q)
      PH_SECOND: begin
        entry_o.chars[0] = b64se_pkg::sym({carry_q[1:0], data_byte_i[7:4]});
        if (final_byte_i) begin
          entry_o.chars[1] = b64se_pkg::sym({data_byte_i[3:0], 2'b00});
          entry_o.chars[2] = b64se_pkg::PAD_CHAR;
          entry_o.last_idx = 2'd2;
        end else begin
          entry_o.last_idx = 2'd0;
          phase_d          = PH_THIRD;
          carry_d          = data_byte_i[3:0];
        end
      end
      PH_THIRD: begin
        entry_o.chars[0] = b64se_pkg::sym({carry_q, data_byte_i[7:6]});
        entry_o.chars[1] = b64se_pkg::sym(data_byte_i[5:0]);
        entry_o.last_idx = 2'd1;
      end
      default: begin
        entry_o.chars[0] = b64se_pkg::sym(data_byte_i[7:2]);
        if (final_byte_i) begin
          entry_o.chars[1] = b64se_pkg::sym({data_byte_i[1:0], 4'b0000});
          entry_o.chars[2] = b64se_pkg::PAD_CHAR;
          entry_o.chars[3] = b64se_pkg::PAD_CHAR;
          entry_o.last_idx = 2'd3;
        end else begin
          entry_o.last_idx = 2'd0;
          phase_d          = PH_SECOND;
          carry_d          = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      carry_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b64se_queue.sv
`default_nettype none

module b64se_queue #(
  parameter int unsigned Depth = b64se_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire b64se_pkg::entry_t entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output b64se_pkg::entry_t      head_o,
  output logic                   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64se_pkg::entry_t slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b64se_back.sv
`default_nettype none

module b64se_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire b64se_pkg::entry_t head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [6:0]             out_char_o,
  output logic                   end_of_text_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [6:0] char_q;
  logic       eot_q;
  logic       load;
  logic       at_last;

  assign at_last = (idx_q == head_i.last_idx);
  assign load    = !empty_i && (!valid_q || ready_i);
  assign pop_o   = load && at_last;

  assign valid_o       = valid_q;
  assign out_char_o    = char_q;
  assign end_of_text_o = eot_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      eot_q  <= head_i.fin && at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;

  // clock period is 8 ns, reset held for RESET_CYCLES clocks
  localparam int unsigned RESET_CYCLES = 7;
  // generous bound: ~350 bytes, up to 4 characters each, with stalls on both sides
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // first character passes the word queue and the output register; extra clocks for the drain
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned RANDOM_BYTES = 320;
  localparam int unsigned IDLE_PERCENT = 20;

  // standard alphabet, first character in the top byte
  localparam logic [511:0] ALPHABET_BITS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // position of the next byte inside its 3-byte group
  typedef enum logic [1:0] {
    GROUP_FIRST,
    GROUP_SECOND,
    GROUP_THIRD
  } group_pos_e;

  typedef struct packed {
    logic [b64se_pkg::CharW-1:0] code;
    logic                        last;
  } b64_char_t;

  // tracks the encoder state and the characters still owed on the output
  class b64_scoreboard;
    b64_char_t        pending_chars[$];
    group_pos_e       pos;
    logic       [3:0] carry;
    int unsigned      errors;

    function new();
      pos    = GROUP_FIRST;
      carry  = 4'd0;
      errors = 0;
    endfunction

    function logic [b64se_pkg::CharW-1:0] letter(input logic [5:0] six);
      return ALPHABET_BITS[8 * (63 - int'(six)) +: b64se_pkg::CharW];
    endfunction

    function void owe(input logic [b64se_pkg::CharW-1:0] code, input logic last);
      b64_char_t c;
      c.code = code;
      c.last = last;
      pending_chars.push_back(c);
    endfunction

    // works out the characters that one accepted byte yields
    function void note_byte(input logic [7:0] b, input logic fin);
      case (pos)
        GROUP_SECOND: begin
          owe(letter({carry[1:0], b[7:4]}), 1'b0);
          if (!fin) begin
            pos   = GROUP_THIRD;
            carry = b[3:0];
            return;
          end
          owe(letter({b[3:0], 2'b00}), 1'b0);
          owe(b64se_pkg::PAD_CHAR, 1'b1);
        end
        GROUP_THIRD: begin
          owe(letter({carry, b[7:6]}), 1'b0);
          owe(letter(b[5:0]), fin);
        end
        default: begin
          owe(letter(b[7:2]), 1'b0);
          if (!fin) begin
            pos   = GROUP_SECOND;
            carry = {2'b00, b[1:0]};
            return;
          end
          owe(letter({b[1:0], 4'b0000}), 1'b0);
          owe(b64se_pkg::PAD_CHAR, 1'b0);
          owe(b64se_pkg::PAD_CHAR, 1'b1);
        end
      endcase
      pos   = GROUP_FIRST;
      carry = 4'd0;
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_char(input logic [b64se_pkg::CharW-1:0] code, input logic eot);
      b64_char_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h end %0b", code, eot));
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        report($sformatf("character 0x%02h, expected 0x%02h", code, want.code));
      end
      if (eot !== want.last) begin
        report($sformatf("end_of_text %0b, expected %0b (char 0x%02h)", eot, want.last,
                         want.code));
      end
    endtask

    function int owed();
      return pending_chars.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  b64se_byte_if byte_ch ();
  b64se_char_if char_ch ();

  base64_stream_encoder_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (char_ch)
  );

  b64_scoreboard sb = new();

  // calm: neither side idles; hold requests are served by the receiver process
  bit          calm;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned random_sent;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // every input known from time zero
  initial begin
    rst_ni             = 1'b0;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = 8'h00;
    byte_ch.final_byte = 1'b0;
    char_ch.ready      = 1'b0;
    calm               = 1'b0;
    hold_asked         = 0;
    hold_served        = 0;
    hold_left          = 0;
    cycle_count        = 0;
    random_sent        = 0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_base64_stream_encoder_unit failed");
      $finish;
    end
  end

  // both channels are observed at the rising edge; characters are checked before
  // the new byte is noted, a byte never yields a character in its own cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_ch.valid && char_ch.ready) begin
        sb.check_char(char_ch.out_char, char_ch.end_of_text);
      end
      if (byte_ch.valid && byte_ch.ready) begin
        sb.note_byte(byte_ch.data_byte, byte_ch.final_byte);
      end
    end
  end

  // receiver: random back-pressure, or a long hold counted here when asked
  always @(negedge clk_i) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      char_ch.ready = 1'b0;
      hold_left--;
    end else if (calm) begin
      char_ch.ready = 1'b1;
    end else begin
      char_ch.ready = ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // offers one word, entered and left at a falling edge; valid stays high on exit
  // so back-to-back words need no drop in between
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      byte_ch.valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    byte_ch.valid      = 1'b1;
    byte_ch.data_byte  = b;
    byte_ch.final_byte = fin;
    do @(posedge clk_i); while (!byte_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
      random_sent++;
    end
  endtask

  task automatic wait_drained();
    byte_ch.valid = 1'b0;
    while (sb.owed() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-byte messages: final at the start of a group, pads with two '='
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two bytes: final in the second slot, one '='
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // three bytes: final in the third slot, no padding
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    // top of the alphabet, '+' and '/'
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // full group passes without a final, then a fresh group starts
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // stretch with no idling on either side
    calm = 1'b1;
    while (random_sent < 40) send_message($urandom_range(1, 9));
    calm = 1'b0;

    // receiver stops for a while, the sender keeps pushing until input stalls
    hold_asked++;
    send_message(12);

    // sender waits for the output to catch up before going on
    wait_drained();

    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(9) == 0) begin
        send_message($urandom_range(10, 30));
      end else begin
        send_message($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("tb_base64_stream_encoder_unit passed");
    end else begin
      $display("tb_base64_stream_encoder_unit failed");
    end
    $finish;
  end

endmodule
